// ----- src/cmm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmm_pkg
// Shared types and constants for the complex matrix multiply unit.
// ----------------------------------------------------------------------------
package cmm_pkg;

  // entry, product and result widths, fixed by the Q4.12 / Q8.24 / Q12.24 formats
  localparam int DATA_W    = 16;
  localparam int ENTRY_W   = 2 * DATA_W;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = 2 * DATA_W + 4;
  localparam int IDX_W     = 3;
  localparam int DIM_W     = 4;
  localparam int CFG_IDX_W = 2;

  // request codes
  localparam logic [1:0] REQ_WR_LEFT  = 2'd0;
  localparam logic [1:0] REQ_WR_RIGHT = 2'd1;
  localparam logic [1:0] REQ_COMPUTE  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS    = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [DATA_W-1:0] real_part;
    logic signed [DATA_W-1:0] imag_part;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [ACC_W-1:0] out_real;
    logic signed [ACC_W-1:0] out_imag;
    logic                    last;
  } out_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;
  } cfg_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic             rd_en;
    logic             first;
    logic             last_term;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
    logic             load;
    logic             load_last;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic acc_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ----- src/cmm_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmm_stream_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface cmm_stream_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/complex_matrix_multiply_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_matrix_multiply_unit
// Loads two complex Q4.12 matrices and streams their Q12.24 product.
// ----------------------------------------------------------------------------
//
//  channel  dir  word         contents
//  in       in   in_word_t    req_type, row_index, col_index, real_part, imag_part
//  out      out  out_word_t   out_row, out_col, out_real, out_imag, last
//  cfg      in   cfg_word_t   index (0 a_rows, 1 inner_len, 2 b_cols), data
//
// write words are taken while idle; a compute word ties up the input side until
// the last product entry sits in the output register
// each product entry issues one store read per term, then waits while the read,
// multiply and accumulate registers drain
// a stalled output holds the sequencer in place; cfg is always ready
// rst is synchronous and clears control state; store contents survive it
//
module complex_matrix_multiply_unit #(
  parameter int MAX_DIM = 8
) (
  input  logic         clk,
  input  logic         rst,
  cmm_stream_if.sink   in,
  cmm_stream_if.source out,
  cmm_stream_if.sink   cfg
);

  cmm_pkg::ctrl_cmd_t cmd;
  cmm_pkg::ctrl_sts_t sts;
  logic in_ready, in_accept, start;

  assign in_accept = in.valid && in_ready;
  assign start     = in_accept && (in.payload.req_type == cmm_pkg::REQ_COMPUTE);
  assign in.ready  = in_ready;
  assign cfg.ready = 1'b1;

  cmm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg.valid),
    .cfg_word (cfg.payload),
    .start    (start),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  cmm_dpath #(.MAX_DIM(MAX_DIM)) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .in_word   (in.payload),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out.ready),
    .out_valid (out.valid),
    .out_word  (out.payload)
  );

  // an entry is loaded only into a free slot and only once all its terms are summed
  a_load_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (sts.acc_done && (!out.valid || out.ready)))
    else $error("product loaded while output slot busy or sum incomplete");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> out.valid)
    else $error("loaded product entry not presented");

  // no store reads and no leftover sum while new words are taken
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    in.ready |-> (!cmd.rd_en && !sts.acc_done))
    else $error("input accepted while a product entry is in progress");

endmodule

// ----- src/cmm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmm_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module cmm_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/cmm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmm_ctrl
// Dimension registers and the sequencer that walks rows, columns and terms.
// ----------------------------------------------------------------------------
module cmm_ctrl #(
  parameter int MAX_DIM = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  cmm_pkg::cfg_word_t  cfg_word,
  input  logic                start,
  input  cmm_pkg::ctrl_sts_t  sts,
  output cmm_pkg::ctrl_cmd_t  cmd,
  output logic                in_ready
);

  localparam logic [cmm_pkg::DIM_W-1:0] MAX_DIM_V = cmm_pkg::DIM_W'(MAX_DIM);

  cmm_pkg::state_t state, state_next;

  logic [cmm_pkg::DIM_W-1:0] a_rows, inner_len, b_cols;
  logic [cmm_pkg::IDX_W-1:0] i, i_next, j, j_next, k, k_next;
  logic [cmm_pkg::DIM_W-1:0] nr, nk, nc;
  logic [cmm_pkg::IDX_W-1:0] nr_m1, nk_m1, nc_m1;

  function automatic logic [cmm_pkg::DIM_W-1:0] clamp_dim(
    input logic [cmm_pkg::DIM_W-1:0] v
  );
    logic [cmm_pkg::DIM_W-1:0] r;
    if (v == '0) begin
      r = cmm_pkg::DIM_W'(1);
    end else if (v > MAX_DIM_V) begin
      r = MAX_DIM_V;
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows    <= cmm_pkg::DIM_RESET;
      inner_len <= cmm_pkg::DIM_RESET;
      b_cols    <= cmm_pkg::DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_word.index)
        cmm_pkg::CFG_A_ROWS:    a_rows    <= cfg_word.data;
        cmm_pkg::CFG_INNER_LEN: inner_len <= cfg_word.data;
        cmm_pkg::CFG_B_COLS:    b_cols    <= cfg_word.data;
        default: ;
      endcase
    end
  end

  assign nr    = clamp_dim(a_rows);
  assign nk    = clamp_dim(inner_len);
  assign nc    = clamp_dim(b_cols);
  assign nr_m1 = cmm_pkg::IDX_W'(nr - cmm_pkg::DIM_W'(1));
  assign nk_m1 = cmm_pkg::IDX_W'(nk - cmm_pkg::DIM_W'(1));
  assign nc_m1 = cmm_pkg::IDX_W'(nc - cmm_pkg::DIM_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cmm_pkg::ST_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.i      = i;
    cmd.j      = j;
    cmd.k      = k;
    case (state)
      cmm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (start) begin
          i_next     = '0;
          j_next     = '0;
          k_next     = '0;
          state_next = cmm_pkg::ST_ISSUE;
        end
      end
      cmm_pkg::ST_ISSUE: begin
        cmd.rd_en     = 1'b1;
        cmd.first     = (k == '0);
        cmd.last_term = (k == nk_m1);
        if (k == nk_m1) begin
          k_next     = '0;
          state_next = cmm_pkg::ST_FINISH;
        end else begin
          k_next = k + cmm_pkg::IDX_W'(1);
        end
      end
      cmm_pkg::ST_FINISH: begin
        // wait for the last term to leave the accumulator and a free output slot
        if (sts.acc_done && sts.out_free) begin
          cmd.load      = 1'b1;
          cmd.load_last = (i == nr_m1) && (j == nc_m1);
          if ((i == nr_m1) && (j == nc_m1)) begin
            state_next = cmm_pkg::ST_IDLE;
          end else begin
            if (j == nc_m1) begin
              j_next = '0;
              i_next = i + cmm_pkg::IDX_W'(1);
            end else begin
              j_next = j + cmm_pkg::IDX_W'(1);
            end
            state_next = cmm_pkg::ST_ISSUE;
          end
        end
      end
      default: begin
        state_next = cmm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/cmm_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmm_dpath
// Matrix stores, complex multiplier stage, accumulator and output register.
// ----------------------------------------------------------------------------
module cmm_dpath #(
  parameter int MAX_DIM = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_accept,
  input  cmm_pkg::in_word_t   in_word,
  input  cmm_pkg::ctrl_cmd_t  cmd,
  output cmm_pkg::ctrl_sts_t  sts,
  input  logic                out_ready,
  output logic                out_valid,
  output cmm_pkg::out_word_t  out_word
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [cmm_pkg::DIM_W-1:0] MAX_DIM_V = cmm_pkg::DIM_W'(MAX_DIM);

  function automatic logic [ADDR_W-1:0] addr_of(
    input logic [cmm_pkg::IDX_W-1:0] row,
    input logic [cmm_pkg::IDX_W-1:0] col
  );
    return ADDR_W'(32'(row) * MAX_DIM + 32'(col));
  endfunction

  logic                       in_range, left_we, right_we;
  logic [ADDR_W-1:0]          waddr, left_raddr, right_raddr;
  logic [cmm_pkg::ENTRY_W-1:0] wdata, left_rdata, right_rdata;

  logic s1_valid, s1_first, s1_last;
  logic s2_valid, s2_first, s2_last;
  logic signed [cmm_pkg::DATA_W-1:0] a_re, a_im, b_re, b_im;
  logic signed [cmm_pkg::PROD_W-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [cmm_pkg::ACC_W-1:0]  acc_re, acc_im, base_re, base_im;
  logic acc_done;

  // write side: entries outside the store are dropped
  assign in_range = ({1'b0, in_word.row_index} < MAX_DIM_V) &&
                    ({1'b0, in_word.col_index} < MAX_DIM_V);
  assign left_we  = in_accept && in_range && (in_word.req_type == cmm_pkg::REQ_WR_LEFT);
  assign right_we = in_accept && in_range && (in_word.req_type == cmm_pkg::REQ_WR_RIGHT);
  assign waddr    = addr_of(in_word.row_index, in_word.col_index);
  assign wdata    = {in_word.real_part, in_word.imag_part};

  assign left_raddr  = addr_of(cmd.i, cmd.k);
  assign right_raddr = addr_of(cmd.k, cmd.j);

  cmm_ram #(.WIDTH(cmm_pkg::ENTRY_W), .DEPTH(DEPTH)) u_left_ram (
    .clk   (clk),
    .we    (left_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (left_raddr),
    .rdata (left_rdata)
  );

  cmm_ram #(.WIDTH(cmm_pkg::ENTRY_W), .DEPTH(DEPTH)) u_right_ram (
    .clk   (clk),
    .we    (right_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (right_raddr),
    .rdata (right_rdata)
  );

  assign a_re = left_rdata[cmm_pkg::ENTRY_W-1:cmm_pkg::DATA_W];
  assign a_im = left_rdata[cmm_pkg::DATA_W-1:0];
  assign b_re = right_rdata[cmm_pkg::ENTRY_W-1:cmm_pkg::DATA_W];
  assign b_im = right_rdata[cmm_pkg::DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.rd_en;
      s2_valid <= s1_valid;
    end
    s1_first <= cmd.first;
    s1_last  <= cmd.last_term;
    s2_first <= s1_first;
    s2_last  <= s1_last;
  end

  // four partial products, registered before the accumulator
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      p_rr <= a_re * b_re;
      p_ii <= a_im * b_im;
      p_ri <= a_re * b_im;
      p_ir <= a_im * b_re;
    end
  end

  assign base_re = s2_first ? '0 : acc_re;
  assign base_im = s2_first ? '0 : acc_im;

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      acc_re <= base_re + cmm_pkg::ACC_W'(p_rr) - cmm_pkg::ACC_W'(p_ii);
      acc_im <= base_im + cmm_pkg::ACC_W'(p_ri) + cmm_pkg::ACC_W'(p_ir);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_done <= 1'b0;
    end else if (cmd.load) begin
      acc_done <= 1'b0;
    end else if (s2_valid && s2_last) begin
      acc_done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_word.out_row  <= cmd.i;
      out_word.out_col  <= cmd.j;
      out_word.out_real <= acc_re;
      out_word.out_imag <= acc_im;
      out_word.last     <= cmd.load_last;
    end
  end

  assign sts.acc_done = acc_done;
  assign sts.out_free = !out_valid || out_ready;

endmodule
